// File: hdl/soft_timer_task_table_core_assert.svh
// Assertion macros for the timer task table checker.
`ifndef SOFT_TIMER_TASK_TABLE_CORE_ASSERT_SVH
`define SOFT_TIMER_TASK_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, masked while in reset.
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, masked while in reset.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/stt_pkg.sv
// Shared types and constants of the timer task table.
`default_nettype none

package stt_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned SEL_W       = 4;
  localparam int unsigned DELAY_W     = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned PROD_W      = COUNT_W + SCALE_W;
  localparam int unsigned HANDLER_W   = 8;
  localparam int unsigned ARG_W       = 16;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned FIRE_CNT_W  = 4;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    K_ADDED   = 3'd0,
    K_FULL    = 3'd1,
    K_DELETED = 3'd2,
    K_BADSLOT = 3'd3,
    K_FIRED   = 3'd4,
    K_IDLE    = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_BAD,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_T_RD,
    ST_T_INC,
    ST_T_MUL,
    ST_T_CMP,
    ST_T_FIN
  } state_e;

  // One slot of the task table as held in the slot RAM.
  typedef struct packed {
    logic [DELAY_W-1:0]   delay;
    logic [COUNT_W-1:0]   count;
    logic                 once;
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     arg_a;
    logic [ARG_W-1:0]     arg_b;
  } entry_t;

  typedef struct packed {
    kind_e                kind;
    logic [SEL_W-1:0]     slot;
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     arg_a;
    logic [ARG_W-1:0]     arg_b;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic inc_en;
    logic mul_en;
  } eval_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/stt_slot_ram.sv
// Slot RAM: one write port, one registered read port.
`default_nettype none

module stt_slot_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire stt_pkg::entry_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output stt_pkg::entry_t      rdata_o
);
  import stt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/stt_eval.sv
// Slot evaluation: saturating count increment, scale product and delay compare.
`default_nettype none

module stt_eval (
  input  wire logic                          clk_i,
  input  wire stt_pkg::eval_ctrl_t           ctrl_i,
  input  wire logic [stt_pkg::COUNT_W-1:0]   count_i,
  input  wire logic [stt_pkg::DELAY_W-1:0]   delay_i,
  input  wire logic [stt_pkg::SCALE_W-1:0]   scale_i,
  output logic      [stt_pkg::COUNT_W-1:0]   count_o,
  output logic                               due_o
);
  import stt_pkg::*;

  logic [COUNT_W-1:0] cnt_q;
  logic [COUNT_W-1:0] cnt_d;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-1:0]  prod_d;

  always_comb begin
    cnt_d  = (count_i == '1) ? count_i : count_i + COUNT_W'(1);
    prod_d = PROD_W'(cnt_q) * PROD_W'(scale_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.inc_en) begin
      cnt_q <= cnt_d;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign count_o = cnt_q;
  assign due_o   = prod_q >= PROD_W'(delay_i);

endmodule

`default_nettype wire

// File: hdl/soft_timer_task_table_core.sv
// Top level of the timer task table: command sequencer, slot flags and result register.
`default_nettype none

// Timer task table with TASK_SLOTS slots. Commands arrive one transaction at a
// time: add (takes the lowest free slot), delete (makes a slot one-shot) and
// tick (advances every slot counter and reports each slot that falls due).
// Slot contents live in a single-port-read RAM; busy flags are flops cleared by
// reset, so no clearing pass is needed. One command is handled at a time and
// in_stall_o is high until it is finished. A tick runs, for each slot, a chain
// of RAM read, saturating increment, 32x16 scale multiply and 48-bit compare
// with write-back, one step per cycle while the compare step is not held by
// the output register, with the next slot's read issued in the compare step.
// A tick yields one "fired" result per due slot, lowest slot first and at most
// eight, the final one flagged with last_o, or a single "nothing fired"
// result. A fired result is held back until the next firing or the end of
// the tick so that last_o can be set on it. Results leave through an output
// register; a write to tick_scale (cfg_we_i) is meant for an idle block.
module soft_timer_task_table_core #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [stt_pkg::SCALE_W-1:0]     cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [stt_pkg::CMD_W-1:0]       cmd_i,
  input  wire logic [stt_pkg::SEL_W-1:0]       slot_sel_i,
  input  wire logic [stt_pkg::DELAY_W-1:0]     delay_ms_i,
  input  wire logic                            one_shot_i,
  input  wire logic [stt_pkg::HANDLER_W-1:0]   handler_id_i,
  input  wire logic [stt_pkg::ARG_W-1:0]       arg_a_i,
  input  wire logic [stt_pkg::ARG_W-1:0]       arg_b_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [stt_pkg::KIND_W-1:0]      kind_o,
  output logic      [stt_pkg::SEL_W-1:0]       slot_out_o,
  output logic      [stt_pkg::HANDLER_W-1:0]   fired_handler_o,
  output logic      [stt_pkg::ARG_W-1:0]       fired_arg_a_o,
  output logic      [stt_pkg::ARG_W-1:0]       fired_arg_b_o,
  output logic                                 last_o
);
  import stt_pkg::*;

  localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  state_e                 state_q, state_d;
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic [FIRE_CNT_W-1:0]  fire_cnt_q, fire_cnt_d;
  logic [TASK_SLOTS-1:0]  busy_q, busy_d;
  logic [SCALE_W-1:0]     scale_q;
  logic                   pend_valid_q, pend_valid_d;
  result_t                pend_q, pend_d;
  logic                   out_valid_q, out_valid_d;
  result_t                out_q, out_d;

  // captured command
  logic [SEL_W-1:0]       sel_q;
  logic [DELAY_W-1:0]     delay_q;
  logic                   once_q;
  logic [HANDLER_W-1:0]   handler_q;
  logic [ARG_W-1:0]       arg_a_q;
  logic [ARG_W-1:0]       arg_b_q;

  logic                   in_acc;
  logic                   out_free;
  logic                   out_load;
  result_t                out_res;
  logic [SLOT_W-1:0]      free_idx;
  logic                   any_free;
  logic                   last_slot;
  logic                   fire;
  logic                   proceed;

  logic                   mem_we;
  logic [SLOT_W-1:0]      mem_waddr;
  entry_t                 mem_wdata;
  logic                   mem_re;
  logic [SLOT_W-1:0]      mem_raddr;
  entry_t                 mem_rdata;

  eval_ctrl_t             ev_ctrl;
  logic [COUNT_W-1:0]     ev_count;
  logic                   ev_due;

  stt_slot_ram #(
    .DEPTH (TASK_SLOTS),
    .AW    (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  stt_eval u_eval (
    .clk_i   (clk_i),
    .ctrl_i  (ev_ctrl),
    .count_i (mem_rdata.count),
    .delay_i (mem_rdata.delay),
    .scale_i (scale_q),
    .count_o (ev_count),
    .due_o   (ev_due)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_slot  = (idx_q == SLOT_W'(TASK_SLOTS - 1));

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx = SLOT_W'(i);
        any_free = 1'b1;
      end
    end
  end

  // Slot falls due; capped at MAX_RESULTS firings per tick.
  assign fire = busy_q[idx_q] && (mem_rdata.handler != '0) && ev_due &&
                (fire_cnt_q < FIRE_CNT_W'(MAX_RESULTS));
  // A new firing pushes the held one out, which needs the output register.
  assign proceed = !fire || !pend_valid_q || out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd_e'(cmd_i))
            CMD_ADD:  state_d = ST_ADD;
            CMD_DEL:  state_d = ({1'b0, slot_sel_i} < (SEL_W + 1)'(TASK_SLOTS)) ?
                                ST_DEL_RD : ST_BAD;
            CMD_TICK: state_d = ST_T_RD;
            CMD_NONE: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD, ST_BAD, ST_DEL_WR, ST_T_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_DEL_RD: state_d = ST_DEL_WR;
      ST_T_RD:   state_d = ST_T_INC;
      ST_T_INC:  state_d = ST_T_MUL;
      ST_T_MUL:  state_d = ST_T_CMP;
      ST_T_CMP: begin
        if (proceed) state_d = last_slot ? ST_T_FIN : ST_T_INC;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;
    ev_ctrl      = '0;
    busy_d       = busy_q;
    idx_d        = idx_q;
    fire_cnt_d   = fire_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_load     = 1'b0;
    out_res      = '0;
    out_res.last = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        idx_d        = '0;
        fire_cnt_d   = '0;
        pend_valid_d = 1'b0;
      end
      ST_ADD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (any_free) begin
            mem_we            = 1'b1;
            mem_waddr         = free_idx;
            mem_wdata.delay   = delay_q;
            mem_wdata.count   = '0;
            mem_wdata.once    = once_q;
            mem_wdata.handler = handler_q;
            mem_wdata.arg_a   = arg_a_q;
            mem_wdata.arg_b   = arg_b_q;
            busy_d[free_idx]  = 1'b1;
            out_res.kind      = K_ADDED;
            out_res.slot      = SEL_W'(free_idx);
          end else begin
            out_res.kind = K_FULL;
          end
        end
      end
      ST_BAD: begin
        out_load     = out_free;
        out_res.kind = K_BADSLOT;
        out_res.slot = sel_q;
      end
      ST_DEL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = sel_q[SLOT_W-1:0];
      end
      ST_DEL_WR: begin
        // read-modify-write of the selected slot: only the one-shot flag changes
        if (out_free) begin
          mem_we         = 1'b1;
          mem_waddr      = sel_q[SLOT_W-1:0];
          mem_wdata.once = 1'b1;
          out_load       = 1'b1;
          out_res.kind   = K_DELETED;
          out_res.slot   = sel_q;
        end
      end
      ST_T_RD: begin
        mem_re = 1'b1;
      end
      ST_T_INC: begin
        ev_ctrl.inc_en = 1'b1;
      end
      ST_T_MUL: begin
        ev_ctrl.mul_en = 1'b1;
      end
      ST_T_CMP: begin
        if (proceed) begin
          mem_we          = 1'b1;
          mem_wdata.count = fire ? '0 : ev_count;
          if (fire) begin
            if (pend_valid_q) begin
              out_load     = 1'b1;
              out_res      = pend_q;
              out_res.last = 1'b0;
            end
            pend_valid_d   = 1'b1;
            pend_d.kind    = K_FIRED;
            pend_d.slot    = SEL_W'(idx_q);
            pend_d.handler = mem_rdata.handler;
            pend_d.arg_a   = mem_rdata.arg_a;
            pend_d.arg_b   = mem_rdata.arg_b;
            pend_d.last    = 1'b1;
            fire_cnt_d     = fire_cnt_q + FIRE_CNT_W'(1);
            if (mem_rdata.once) busy_d[idx_q] = 1'b0;
          end
          if (!last_slot) begin
            // next slot read overlaps this write-back; addresses differ
            idx_d     = idx_q + SLOT_W'(1);
            mem_re    = 1'b1;
            mem_raddr = idx_q + SLOT_W'(1);
          end
        end
      end
      ST_T_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_valid_q) begin
            out_res      = pend_q;
            out_res.last = 1'b1;
          end else begin
            out_res.kind = K_IDLE;
          end
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Output register: loads only when empty or being taken.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = out_res;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
      out_d       = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      fire_cnt_q   <= '0;
      busy_q       <= '0;
      scale_q      <= SCALE_RESET;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      fire_cnt_q   <= fire_cnt_d;
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) scale_q <= cfg_wdata_i;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (in_acc) begin
      sel_q     <= slot_sel_i;
      delay_q   <= delay_ms_i;
      once_q    <= one_shot_i;
      handler_q <= handler_id_i;
      arg_a_q   <= arg_a_i;
      arg_b_q   <= arg_b_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign slot_out_o      = out_q.slot;
  assign fired_handler_o = out_q.handler;
  assign fired_arg_a_o   = out_q.arg_a;
  assign fired_arg_b_o   = out_q.arg_b;
  assign last_o          = out_q.last;

endmodule

`default_nettype wire

// File: hdl/stt_checker.sv
// Port-level checker for the timer task table, bound to the top level.
`default_nettype none

`include "soft_timer_task_table_core_assert.svh"

module stt_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cfg_we_i,
  input wire logic [stt_pkg::SCALE_W-1:0]     cfg_wdata_i,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic [stt_pkg::CMD_W-1:0]       cmd_i,
  input wire logic [stt_pkg::SEL_W-1:0]       slot_sel_i,
  input wire logic [stt_pkg::DELAY_W-1:0]     delay_ms_i,
  input wire logic                            one_shot_i,
  input wire logic [stt_pkg::HANDLER_W-1:0]   handler_id_i,
  input wire logic [stt_pkg::ARG_W-1:0]       arg_a_i,
  input wire logic [stt_pkg::ARG_W-1:0]       arg_b_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [stt_pkg::KIND_W-1:0]      kind_o,
  input wire logic [stt_pkg::SEL_W-1:0]       slot_out_o,
  input wire logic [stt_pkg::HANDLER_W-1:0]   fired_handler_o,
  input wire logic [stt_pkg::ARG_W-1:0]       fired_arg_a_o,
  input wire logic [stt_pkg::ARG_W-1:0]       fired_arg_b_o,
  input wire logic                            last_o
);
  import stt_pkg::*;

  // a stalled result stays offered
  `STT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // only fired results carry handler and arguments
  `STT_ASSERT_NOW(a_nonfired_zero, out_valid_o && (kind_o != K_FIRED), (fired_handler_o == '0) && (fired_arg_a_o == '0) && (fired_arg_b_o == '0), "payload on non-fired result")

  // every non-fired result closes its transaction
  `STT_ASSERT_NOW(a_nonfired_last, out_valid_o && (kind_o != K_FIRED), last_o, "non-fired result without last")

  // a slot without a handler never fires
  `STT_ASSERT_NOW(a_fired_handler, out_valid_o && (kind_o == K_FIRED), fired_handler_o != '0, "fired with null handler")

  // a real command occupies the block for at least the next cycle
  `STT_ASSERT_NEXT(a_busy_after, in_valid_i && !in_stall_o && (cmd_i != CMD_NONE), in_stall_o, "no stall after command")

endmodule

bind soft_timer_task_table_core stt_checker u_stt_checker (.*);

`default_nettype wire
